[rtl/core/dcn_pkg.sv]
`timescale 1ns / 1ps
package dcn_pkg;

  localparam int CLASS_COUNT = 5;

  // Configuration register indexes.
  localparam logic [3:0] REG_MIN_SCORE      = 4'd0;
  localparam logic [3:0] REG_OVERLAP_RATIO  = 4'd1;
  localparam logic [3:0] REG_INV_SCALE      = 4'd2;
  localparam logic [3:0] REG_PAD_HORIZ      = 4'd3;
  localparam logic [3:0] REG_PAD_TOP        = 4'd4;
  localparam logic [3:0] REG_IMAGE_WIDTH    = 4'd5;
  localparam logic [3:0] REG_IMAGE_HEIGHT   = 4'd6;
  localparam logic [3:0] REG_CLASSES_IN_USE = 4'd7;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] score_0;
    logic [15:0] score_1;
    logic [15:0] score_2;
    logic [15:0] score_3;
    logic [15:0] score_4;
    logic        last_anchor;
  } item_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] confidence;
    logic [2:0]  class_id;
    logic        last_result;
    logic        none_kept;
    logic        overflow;
  } result_t;

  // One stored candidate box.
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] score;
    logic [2:0]  class_id;
  } entry_t;

  // Per-cell control for the candidate chain.
  typedef struct packed {
    logic insert;
    logic shift;
    logic load;
    logic valid;
  } cell_ctl_t;

endpackage

[rtl/core/dcn_cell.sv]
`timescale 1ns / 1ps
module dcn_cell (
  input  logic               clk,
  input  dcn_pkg::cell_ctl_t ctl,
  input  dcn_pkg::entry_t    new_entry,
  input  dcn_pkg::entry_t    prev_entry,
  input  logic               prev_ge,
  input  dcn_pkg::entry_t    next_entry,
  output dcn_pkg::entry_t    entry,
  output logic               ge
);

  // This cell keeps its place when it already ranks at or above the new box.
  assign ge = ctl.valid && (entry.score >= new_entry.score);

  // Sorted insert moves lower entries one cell down; pop moves all up one.
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (!ge) begin
        entry <= prev_ge ? new_entry : prev_entry;
      end
    end else if (ctl.shift) begin
      entry <= next_entry;
    end else if (ctl.load) begin
      entry <= new_entry;
    end
  end

endmodule

[rtl/core/dcn_intake.sv]
`timescale 1ns / 1ps
module dcn_intake (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  dcn_pkg::item_t      item,
  input  logic [15:0]         min_score,
  input  logic [15:0]         inv_scale,
  input  logic [8:0]          pad_horiz,
  input  logic [8:0]          pad_top,
  input  logic [11:0]         image_width,
  input  logic [11:0]         image_height,
  input  logic [2:0]          classes_in_use,
  output logic                out_valid,
  output dcn_pkg::entry_t     out_entry,
  output logic                in_flight
);

  logic [15:0] scores [dcn_pkg::CLASS_COUNT];
  logic [2:0]  ncls;
  logic [15:0] best;
  logic [2:0]  best_c;
  logic signed [19:0] e_x1, e_y1, e_x2, e_y2;

  logic               s1_valid;
  logic signed [19:0] s1_edge [4];
  logic [15:0]        s1_score;
  logic [2:0]         s1_class;

  logic               s2_valid;
  logic signed [36:0] s2_prod [4];
  logic [15:0]        s2_score;
  logic [2:0]         s2_class;

  logic [15:0] mapped [4];

  assign scores[0] = item.score_0;
  assign scores[1] = item.score_1;
  assign scores[2] = item.score_2;
  assign scores[3] = item.score_3;
  assign scores[4] = item.score_4;

  // Best class among the scores in use; the lowest index wins a tie.
  always_comb begin
    ncls = (classes_in_use > 3'(dcn_pkg::CLASS_COUNT)) ? 3'(dcn_pkg::CLASS_COUNT)
                                                        : classes_in_use;
    best   = '0;
    best_c = '0;
    for (int c = 0; c < dcn_pkg::CLASS_COUNT; c++) begin
      if ((3'(c) < ncls) && (scores[c] > best)) begin
        best   = scores[c];
        best_c = 3'(c);
      end
    end
  end

  // Edges in 1/128 model pixels with the padding removed.
  always_comb begin
    e_x1 = $signed({3'b0, item.center_x, 1'b0}) - $signed({4'b0, item.box_width})
         - $signed({4'b0, pad_horiz, 7'b0});
    e_x2 = $signed({3'b0, item.center_x, 1'b0}) + $signed({4'b0, item.box_width})
         - $signed({4'b0, pad_horiz, 7'b0});
    e_y1 = $signed({3'b0, item.center_y, 1'b0}) - $signed({4'b0, item.box_height})
         - $signed({4'b0, pad_top, 7'b0});
    e_y2 = $signed({3'b0, item.center_y, 1'b0}) + $signed({4'b0, item.box_height})
         - $signed({4'b0, pad_top, 7'b0});
  end

  // Stage one: class pick and edges; stage two: scale products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && (best != 16'd0) && (best >= min_score);
      s2_valid <= s1_valid;
    end
    s1_edge[0] <= e_x1;
    s1_edge[1] <= e_y1;
    s1_edge[2] <= e_x2;
    s1_edge[3] <= e_y2;
    s1_score   <= best;
    s1_class   <= best_c;
    for (int k = 0; k < 4; k++) begin
      s2_prod[k] <= 37'(s1_edge[k]) * 37'($signed({1'b0, inv_scale}));
    end
    s2_score <= s1_score;
    s2_class <= s1_class;
  end

  // Negative products go to zero, then truncate to Q12.4 and clamp.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [21:0] v;
      logic [15:0] lim;
      v   = s2_prod[k][36:15];
      lim = (k % 2 == 0) ? {image_width, 4'b0} : {image_height, 4'b0};
      if (s2_prod[k] <= 0) begin
        mapped[k] = '0;
      end else if (v > {6'b0, lim}) begin
        mapped[k] = lim;
      end else begin
        mapped[k] = v[15:0];
      end
    end
  end

  assign out_valid            = s2_valid;
  assign out_entry.left       = mapped[0];
  assign out_entry.top        = mapped[1];
  assign out_entry.right      = mapped[2];
  assign out_entry.bottom     = mapped[3];
  assign out_entry.score      = s2_score;
  assign out_entry.class_id   = s2_class;
  assign in_flight            = s1_valid || s2_valid;

endmodule

[rtl/core/dcn_iou.sv]
`timescale 1ns / 1ps
module dcn_iou (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dcn_pkg::entry_t a,
  input  dcn_pkg::entry_t b,
  input  logic [15:0]     overlap_ratio,
  output logic            done,
  output logic            over
);

  logic [3:0]  vld;
  logic [15:0] iw, ih, wa, ha, wb, hb;
  logic [31:0] inter2, area_a, area_b;
  logic [31:0] inter3;
  logic [32:0] uni3;
  logic [47:0] lhs4;
  logic [48:0] rhs4;

  // Intersection extents, combinational from the operands.
  logic [15:0] ix1, iy1, ix2, iy2;
  always_comb begin
    ix1 = (a.left > b.left) ? a.left : b.left;
    iy1 = (a.top > b.top) ? a.top : b.top;
    ix2 = (a.right < b.right) ? a.right : b.right;
    iy2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
  end

  // Four stages: extents, areas, union, threshold product.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], start};
    end
    iw     <= (ix2 > ix1) ? ix2 - ix1 : '0;
    ih     <= (iy2 > iy1) ? iy2 - iy1 : '0;
    wa     <= a.right - a.left;
    ha     <= a.bottom - a.top;
    wb     <= b.right - b.left;
    hb     <= b.bottom - b.top;
    inter2 <= iw * ih;
    area_a <= wa * ha;
    area_b <= wb * hb;
    inter3 <= inter2;
    uni3   <= {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter2};
    lhs4   <= {inter3, 16'b0};
    rhs4   <= overlap_ratio * uni3;
  end

  assign done = vld[3];
  assign over = {1'b0, lhs4} > rhs4;

endmodule

[rtl/core/detector_decode_class_nms_core.sv]
`timescale 1ns / 1ps
// An anchor's box passes the intake's pick and scale stages and is then placed in the chain.
// Throughput: one anchor per cycle while a frame loads; busy holds from the last anchor.
// After the last anchor the intake drains; then each box is tested against a kept box in
// the single overlap unit; each kept box goes through POP, SCAN_POP and EMIT to its result.
// Reset (rst, synchronous) restores register defaults and empties the frame.
// Results are strobed for one cycle; the receiver cannot stall.
module detector_decode_class_nms_core #(
  parameter int MAX_CANDIDATES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dcn_pkg::item_t    item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              result_valid,
  output dcn_pkg::result_t  result
);

  localparam int CW = $clog2(MAX_CANDIDATES + 1);

  typedef enum logic [2:0] {IDLE, DRAIN, POP, SCAN_POP, SCAN_WAIT, EMIT} phase_t;

  phase_t phase;
  logic [15:0] min_score, overlap_ratio, inv_scale;
  logic [8:0]  pad_horiz, pad_top;
  logic [11:0] image_width, image_height;
  logic [2:0]  classes_in_use;

  logic [CW-1:0] cnt, scan_left;
  logic          overflow_seen;
  dcn_pkg::entry_t ref_e, probe_e;

  logic            accept;
  logic            in_valid_i, in_flight;
  dcn_pkg::entry_t in_entry;
  logic            do_insert, do_shift, do_append;
  logic            iou_done, iou_over;
  dcn_pkg::entry_t chain_new;

  dcn_pkg::entry_t cell_entry [MAX_CANDIDATES];
  logic            cell_ge    [MAX_CANDIDATES];

  assign accept    = start && !busy;
  assign busy      = (phase != IDLE);
  assign cfg_ready = 1'b1;

  // Configuration register file; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_score      <= 16'd32768;
      overlap_ratio  <= 16'd29491;
      inv_scale      <= 16'd4096;
      pad_horiz      <= '0;
      pad_top        <= '0;
      image_width    <= 12'd512;
      image_height   <= 12'd512;
      classes_in_use <= 3'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dcn_pkg::REG_MIN_SCORE:      min_score      <= cfg_data;
        dcn_pkg::REG_OVERLAP_RATIO:  overlap_ratio  <= cfg_data;
        dcn_pkg::REG_INV_SCALE:      inv_scale      <= cfg_data;
        dcn_pkg::REG_PAD_HORIZ:      pad_horiz      <= cfg_data[8:0];
        dcn_pkg::REG_PAD_TOP:        pad_top        <= cfg_data[8:0];
        dcn_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[11:0];
        dcn_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data[11:0];
        dcn_pkg::REG_CLASSES_IN_USE: classes_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  dcn_intake u_intake (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (accept),
    .item           (item),
    .min_score      (min_score),
    .inv_scale      (inv_scale),
    .pad_horiz      (pad_horiz),
    .pad_top        (pad_top),
    .image_width    (image_width),
    .image_height   (image_height),
    .classes_in_use (classes_in_use),
    .out_valid      (in_valid_i),
    .out_entry      (in_entry),
    .in_flight      (in_flight)
  );

  // Chain operations for this cycle.
  assign do_insert = in_valid_i && (cnt < CW'(MAX_CANDIDATES));
  assign do_shift  = (phase == POP && cnt != '0) || (phase == SCAN_POP && scan_left != '0);
  assign do_append = (phase == SCAN_WAIT) && iou_done &&
                     !(iou_over && (probe_e.class_id == ref_e.class_id));
  assign chain_new = do_insert ? in_entry : probe_e;

  // Row of sorted candidate cells.
  for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_cell
    dcn_pkg::cell_ctl_t ctl;
    assign ctl.insert = do_insert;
    assign ctl.shift  = do_shift;
    assign ctl.load   = do_append && (cnt == CW'(i));
    assign ctl.valid  = (CW'(i) < cnt);
    dcn_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (chain_new),
      .prev_entry ((i == 0) ? chain_new : cell_entry[(i == 0) ? 0 : i - 1]),
      .prev_ge    ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i - 1]),
      .next_entry (cell_entry[(i == MAX_CANDIDATES - 1) ? i : i + 1]),
      .entry      (cell_entry[i]),
      .ge         (cell_ge[i])
    );
  end

  dcn_iou u_iou (
    .clk           (clk),
    .rst           (rst),
    .start         (phase == SCAN_POP && scan_left != '0),
    .a             (ref_e),
    .b             (cell_entry[0]),
    .overlap_ratio (overlap_ratio),
    .done          (iou_done),
    .over          (iou_over)
  );

  // Frame sequencer: load, then pop each survivor and sweep the rest past it.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= IDLE;
      cnt           <= '0;
      scan_left     <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= ((phase == POP) && (cnt == '0)) || (phase == EMIT);
      if (in_valid_i) begin
        if (do_insert) begin
          cnt <= cnt + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      case (phase)
        IDLE: begin
          if (accept && item.last_anchor) begin
            phase <= DRAIN;
          end
        end
        DRAIN: begin
          if (!in_flight && !in_valid_i) begin
            phase <= POP;
          end
        end
        POP: begin
          if (cnt == '0) begin
            // Nothing kept in this frame.
            result.left        <= '0;
            result.top         <= '0;
            result.right       <= '0;
            result.bottom      <= '0;
            result.confidence  <= '0;
            result.class_id    <= '0;
            result.none_kept   <= 1'b1;
            result.last_result <= 1'b1;
            result.overflow    <= overflow_seen;
            overflow_seen      <= 1'b0;
            phase              <= IDLE;
          end else begin
            ref_e     <= cell_entry[0];
            cnt       <= cnt - 1'b1;
            scan_left <= cnt - 1'b1;
            phase     <= SCAN_POP;
          end
        end
        SCAN_POP: begin
          if (scan_left == '0) begin
            phase <= EMIT;
          end else begin
            probe_e   <= cell_entry[0];
            cnt       <= cnt - 1'b1;
            scan_left <= scan_left - 1'b1;
            phase     <= SCAN_WAIT;
          end
        end
        SCAN_WAIT: begin
          if (iou_done) begin
            if (do_append) begin
              cnt <= cnt + 1'b1;
            end
            phase <= SCAN_POP;
          end
        end
        EMIT: begin
          result.left        <= ref_e.left;
          result.top         <= ref_e.top;
          result.right       <= ref_e.right;
          result.bottom      <= ref_e.bottom;
          result.confidence  <= ref_e.score;
          result.class_id    <= ref_e.class_id;
          result.last_result <= (cnt == '0);
          result.none_kept   <= 1'b0;
          result.overflow    <= overflow_seen;
          if (cnt == '0) begin
            overflow_seen <= 1'b0;
            phase         <= IDLE;
          end else begin
            phase <= POP;
          end
        end
        default: phase <= IDLE;
      endcase
    end
  end

endmodule
